/* rtl/core/vpl_pkg.sv */
// ----------------------------------------------------------------------------
// vpl_pkg: shared types and constants of the velocity PI loop
// Register indexes, fixed field widths, reset values and the command word
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package vpl_pkg;

    // Q16 fixed point
    localparam int FRAC_BITS = 16;
    localparam int Q16_ONE   = 65536;

    // Fixed field widths
    localparam int GAIN_W     = 24;
    localparam int WEIGHT_W   = 17;
    localparam int LIMIT_W    = 15;
    localparam int SUM_W      = 16;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_A_W    = 25;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 8'd3;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] RST_PROP_GAIN = -24'sd39322;
    localparam logic signed [GAIN_W-1:0] RST_INT_GAIN  = -24'sd197;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT    = 17'd45875;
    localparam logic [LIMIT_W-1:0]       RST_LIMIT     = 15'd15000;

    // Operand pair presented to the shared multiplier
    typedef enum logic [1:0] {
        MSEL_ERR_NW,  // (1 - w) * error
        MSEL_FE_W,    // w * previous filtered error
        MSEL_FE_KP,   // Kp * filtered error
        MSEL_IS_KI    // Ki * integral
    } t_mul_sel;

    typedef struct packed {
        logic     load_err;
        t_mul_sel mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     upd_filt;
        logic     upd_sum;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

/* rtl/core/vpl_if.sv */
// ----------------------------------------------------------------------------
// vpl_if: handshake channels of the velocity PI loop
// Input sample channel, drive value channel and register write channel.
// ----------------------------------------------------------------------------
interface vpl_in_if #(parameter int COUNT_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COUNT_BITS-1:0] speed_setpoint;
    logic signed [COUNT_BITS-1:0] left_count;
    logic signed [COUNT_BITS-1:0] right_count;

    modport source (output valid, speed_setpoint, left_count, right_count, input ready);
    modport sink   (input valid, speed_setpoint, left_count, right_count, output ready);
endinterface

interface vpl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vpl_pkg::DRIVE_W-1:0]   drive_value;

    modport source (output valid, drive_value, input ready);
    modport sink   (input valid, drive_value, output ready);
endinterface

interface vpl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vpl_pkg::CFG_IDX_W-1:0]     index;
    logic [vpl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/vpl_ctrl.sv */
// ----------------------------------------------------------------------------
// vpl_ctrl: sequencer of the velocity PI loop
// Steps one sample through the shared multiplier and owns the output valid.
// ----------------------------------------------------------------------------
module vpl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vpl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_E,
        S_MUL_F,
        S_ACC_F,
        S_FILT,
        S_SUM,
        S_MUL_I,
        S_ACC_D,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.mul_sel  = vpl_pkg::MSEL_ERR_NW;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = S_MUL_E;
                end
            end
            S_MUL_E: begin
                o_cmd.mul_sel = vpl_pkg::MSEL_ERR_NW;
                n_state       = S_MUL_F;
            end
            S_MUL_F: begin
                o_cmd.mul_sel  = vpl_pkg::MSEL_FE_W;
                o_cmd.acc_load = 1'b1;
                n_state        = S_ACC_F;
            end
            S_ACC_F: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_FILT;
            end
            S_FILT: begin
                o_cmd.upd_filt = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.upd_sum = 1'b1;
                o_cmd.mul_sel = vpl_pkg::MSEL_FE_KP;
                n_state       = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.mul_sel  = vpl_pkg::MSEL_IS_KI;
                o_cmd.acc_load = 1'b1;
                n_state        = S_ACC_D;
            end
            S_ACC_D: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/vpl_dpath.sv */
// ----------------------------------------------------------------------------
// vpl_dpath: datapath of the velocity PI loop
// Registers, loop state, one shared multiplier and its accumulator.
// ----------------------------------------------------------------------------
module vpl_dpath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vpl_pkg::t_dp_cmd                    i_cmd,
    input  vpl_pkg::t_cfg_wr                    i_cfg,
    input  logic signed [COUNT_BITS-1:0]        i_speed_setpoint,
    input  logic signed [COUNT_BITS-1:0]        i_left_count,
    input  logic signed [COUNT_BITS-1:0]        i_right_count,
    output logic signed [vpl_pkg::DRIVE_W-1:0]  o_drive_value
);

    localparam int FE_W  = COUNT_BITS + 2;
    localparam int E3_W  = COUNT_BITS + 3;
    localparam int BW    = (FE_W > vpl_pkg::SUM_W) ? FE_W : vpl_pkg::SUM_W;
    localparam int SW    = BW + 1;
    localparam int PW    = vpl_pkg::MUL_A_W + BW;
    localparam int AW    = PW + 1;
    localparam int QW    = AW - vpl_pkg::FRAC_BITS;

    // Configuration registers
    logic signed [vpl_pkg::GAIN_W-1:0] r_kp, r_ki;
    logic [vpl_pkg::WEIGHT_W-1:0]      r_fw;
    logic [vpl_pkg::LIMIT_W-1:0]       r_il;

    // Loop state and working registers
    logic signed [FE_W-1:0]            r_fe;
    logic signed [vpl_pkg::SUM_W-1:0]  r_is;
    logic signed [FE_W-1:0]            r_err;
    logic signed [PW-1:0]              r_prod;
    logic signed [AW-1:0]              r_acc;
    logic signed [vpl_pkg::DRIVE_W-1:0] r_drive;

    logic signed [E3_W-1:0]            e3;
    logic signed [E3_W-1:0]            e3_b;
    logic [vpl_pkg::WEIGHT_W-1:0]      w_eff, w_inv;
    logic signed [vpl_pkg::MUL_A_W-1:0] op_a;
    logic signed [BW-1:0]              op_b;
    logic signed [AW-1:0]              acc_b;
    logic signed [QW-1:0]              quot;
    logic signed [SW-1:0]              s_raw, s_lim, s_clamp;
    logic signed [vpl_pkg::DRIVE_W-1:0] drive_sat;

    // Mean of the counts minus the target, rounded toward zero.
    always_comb begin
        e3   = E3_W'(i_left_count) + E3_W'(i_right_count) - (E3_W'(i_speed_setpoint) <<< 1);
        e3_b = e3 + E3_W'($signed({1'b0, e3[E3_W-1]}));
    end

    // Weights above one hold the filter.
    always_comb begin
        w_eff = (r_fw > vpl_pkg::WEIGHT_W'(vpl_pkg::Q16_ONE)) ?
                vpl_pkg::WEIGHT_W'(vpl_pkg::Q16_ONE) : r_fw;
        w_inv = vpl_pkg::WEIGHT_W'(vpl_pkg::Q16_ONE) - w_eff;
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            vpl_pkg::MSEL_ERR_NW: begin
                op_a = $signed({8'd0, w_inv});
                op_b = BW'(r_err);
            end
            vpl_pkg::MSEL_FE_W: begin
                op_a = $signed({8'd0, w_eff});
                op_b = BW'(r_fe);
            end
            vpl_pkg::MSEL_FE_KP: begin
                op_a = vpl_pkg::MUL_A_W'(r_kp);
                op_b = BW'(r_fe);
            end
            vpl_pkg::MSEL_IS_KI: begin
                op_a = vpl_pkg::MUL_A_W'(r_ki);
                op_b = BW'(r_is);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Accumulator divided by 2^16, rounded toward zero.
    always_comb begin
        acc_b = r_acc[AW-1] ? (r_acc + AW'(vpl_pkg::Q16_ONE - 1)) : r_acc;
        quot  = acc_b[AW-1:vpl_pkg::FRAC_BITS];
    end

    always_comb begin
        s_raw = SW'(r_is) + SW'(r_fe);
        s_lim = SW'($signed({1'b0, r_il}));
        if (s_raw > s_lim) begin
            s_clamp = s_lim;
        end else if (s_raw < -s_lim) begin
            s_clamp = -s_lim;
        end else begin
            s_clamp = s_raw;
        end
    end

    always_comb begin
        if (quot > QW'(32767)) begin
            drive_sat = 16'sh7FFF;
        end else if (quot < QW'(-32768)) begin
            drive_sat = 16'sh8000;
        end else begin
            drive_sat = quot[vpl_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= vpl_pkg::RST_PROP_GAIN;
            r_ki <= vpl_pkg::RST_INT_GAIN;
            r_fw <= vpl_pkg::RST_WEIGHT;
            r_il <= vpl_pkg::RST_LIMIT;
            r_fe <= '0;
            r_is <= '0;
        end else begin
            if (i_cfg.en) begin
                unique case (i_cfg.index)
                    vpl_pkg::CFG_PROP_GAIN: r_kp <= i_cfg.data;
                    vpl_pkg::CFG_INT_GAIN:  r_ki <= i_cfg.data;
                    vpl_pkg::CFG_WEIGHT:    r_fw <= i_cfg.data[vpl_pkg::WEIGHT_W-1:0];
                    vpl_pkg::CFG_LIMIT:     r_il <= i_cfg.data[vpl_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd_filt) begin
                r_fe <= quot[FE_W-1:0];
            end
            if (i_cmd.upd_sum) begin
                r_is <= s_clamp[vpl_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (i_cmd.load_err) begin
            r_err <= e3_b[E3_W-1:1];
        end
        if (i_cmd.acc_load) begin
            r_acc <= AW'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_drive <= drive_sat;
        end
    end

    assign o_drive_value = r_drive;

endmodule

/* rtl/core/velocity_pi_with_lowpass.sv */
// ----------------------------------------------------------------------------
// velocity_pi_with_lowpass: velocity loop of a balancing robot
// PI controller on the mean wheel speed error, with a first-order low-pass
// filter in front of it and a symmetric clamp on the integral.
// ----------------------------------------------------------------------------
// Each accepted word carries a target speed and the two wheel encoder
// counts of one control period, and yields exactly one drive word. The
// error is the mean of the counts minus the target, smoothed by
// (1 - w) * error + w * previous, integrated and clamped to plus or minus
// the integral limit; the drive is Kp * filtered + Ki * integral in Q16,
// every step rounded toward zero and the result saturated to 16 bits. The
// four products of each sample pass one at a time through a single shared
// multiplier and its accumulator, so a new sample is accepted only once
// the previous one has left its last step. The next sample may be accepted
// while the previous drive word still waits to be taken; it then waits in
// its last step until the output register is free. Register writes are
// always accepted and should be made only while the block is idle; a
// weight above one is treated as one.
// ----------------------------------------------------------------------------
module velocity_pi_with_lowpass #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vpl_in_if.sink      i_in,
    vpl_out_if.source   o_out,
    vpl_cfg_if.sink     i_cfg
);

    vpl_pkg::t_dp_cmd cmd;
    vpl_pkg::t_cfg_wr cfg_wr;

    // The register port never stalls.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        cfg_wr.en    = i_cfg.valid;
        cfg_wr.index = i_cfg.index;
        cfg_wr.data  = i_cfg.data;
    end

    // The controller steps the sample through the datapath and owns both
    // handshakes; the datapath holds the registers and the loop state.
    vpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    vpl_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg_wr),
        .i_speed_setpoint (i_in.speed_setpoint),
        .i_left_count     (i_in.left_count),
        .i_right_count    (i_in.right_count),
        .o_drive_value    (o_out.drive_value)
    );

endmodule

/* tb/vpl_drive_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vpl_drive_checker: scoreboard for the velocity PI loop
// Watches the sample, drive and register channels, keeps its own copy of the
// loop state and settings, and compares every drive word with its prediction.
// ----------------------------------------------------------------------------
module vpl_drive_checker
    import vpl_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vpl_in_if    i_in,
    vpl_out_if   i_out,
    vpl_cfg_if   i_cfg,
    output int   o_mismatch_count,
    output int   o_outstanding
);

    localparam int FILT_W      = COUNT_BITS + 2;

    // Settings as the block holds them
    logic signed [GAIN_W-1:0]   prop_gain;
    logic signed [GAIN_W-1:0]   integ_gain;
    logic        [WEIGHT_W-1:0] lp_weight;
    logic        [LIMIT_W-1:0]  integ_limit;

    // Loop state
    logic signed [FILT_W-1:0]   filt_state;
    logic signed [SUM_W-1:0]    integ_state;

    logic signed [DRIVE_W-1:0]  expected_drive[$];
    logic signed [DRIVE_W-1:0]  oldest;
    int                         mismatches = 0;

    // One control period: filter the mean speed error, integrate with clamp,
    // and form the saturated PI drive. Every division rounds toward zero.
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [COUNT_BITS-1:0] target,
        input logic signed [COUNT_BITS-1:0] left,
        input logic signed [COUNT_BITS-1:0] right
    );
        longint w, err, filt, total, bound, acc, drive;
        w     = (longint'(lp_weight) > Q16_ONE) ? longint'(Q16_ONE) : longint'(lp_weight);
        err   = (longint'(left) + longint'(right) - 2 * longint'(target)) / 2;
        filt  = ((Q16_ONE - w) * err + w * longint'(filt_state)) / Q16_ONE;
        bound = longint'(integ_limit);
        total = longint'(integ_state) + filt;
        if (total > bound) total = bound;
        if (total < -bound) total = -bound;
        acc   = longint'(prop_gain) * filt + longint'(integ_gain) * total;
        drive = acc / Q16_ONE;
        if (drive > 32767) drive = 32767;
        if (drive < -32768) drive = -32768;
        filt_state  = FILT_W'(filt);
        integ_state = SUM_W'(total);
        return DRIVE_W'(drive);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prop_gain   = RST_PROP_GAIN;
            integ_gain  = RST_INT_GAIN;
            lp_weight   = RST_WEIGHT;
            integ_limit = RST_LIMIT;
            filt_state  = '0;
            integ_state = '0;
            expected_drive.delete();
        end else begin
            // Results are taken before new samples are predicted, so a word
            // leaving and one arriving on the same edge stay in order.
            if (i_out.valid && i_out.ready) begin
                if (expected_drive.size() == 0) begin
                    mismatches++;
                    $display("%0t: drive word with none expected: expected none, got %0d",
                             $time, i_out.drive_value);
                end else begin
                    oldest = expected_drive.pop_front();
                    if (i_out.drive_value !== oldest) begin
                        mismatches++;
                        $display("%0t: drive_value mismatch: expected %0d, got %0d",
                                 $time, oldest, i_out.drive_value);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PROP_GAIN: prop_gain   = i_cfg.data[GAIN_W-1:0];
                    CFG_INT_GAIN:  integ_gain  = i_cfg.data[GAIN_W-1:0];
                    CFG_WEIGHT:    lp_weight   = i_cfg.data[WEIGHT_W-1:0];
                    CFG_LIMIT:     integ_limit = i_cfg.data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_drive.push_back(predict_drive(i_in.speed_setpoint,
                                                       i_in.left_count,
                                                       i_in.right_count));
        end
        o_mismatch_count <= mismatches;
        o_outstanding    <= expected_drive.size();
    end

endmodule

/* tb/velocity_pi_with_lowpass_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_pi_with_lowpass_tb: stimulus and verdict for the velocity PI loop
// Drives sample words in random bursts under a randomly stalling receiver,
// reprograms the gains, weight and clamp between phases, and leaves the
// checking to the scoreboard instantiated beside the block.
// ----------------------------------------------------------------------------
module velocity_pi_with_lowpass_tb;
    import vpl_pkg::*;

    localparam int COUNT_BITS       = 16;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    // Idle margin added once every predicted drive word has been taken.
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int RANDOM_PHASES    = 10;
    localparam int WORDS_PER_PHASE  = 163;
    localparam int CYCLE_LIMIT      = 500000;

    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    localparam logic [CFG_DATA_W-1:0] GAIN_MAX   = 24'h7FFFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_MIN   = 24'h800000;
    localparam logic [CFG_DATA_W-1:0] WEIGHT_ONE = 24'd65536;
    localparam logic [CFG_DATA_W-1:0] WEIGHT_TOP = 24'h01FFFF;
    localparam logic [CFG_DATA_W-1:0] LIMIT_TOP  = 24'd32767;
    // An index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatch_count;
    int   outstanding;
    int   cycle_count   = 0;
    int   hold_requests = 0;

    vpl_in_if #(.COUNT_BITS(COUNT_BITS)) in_ch();
    vpl_out_if                           out_ch();
    vpl_cfg_if                           cfg_ch();

    velocity_pi_with_lowpass #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    vpl_drive_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (in_ch),
        .i_out            (out_ch),
        .i_cfg            (cfg_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost drive word ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one sample word and hold it until the block takes it. Valid is
    // left high, so back-to-back words need no extra cycle.
    task automatic send_sample(input logic signed [COUNT_BITS-1:0] target,
                               input logic signed [COUNT_BITS-1:0] left,
                               input logic signed [COUNT_BITS-1:0] right);
        in_ch.valid          <= 1'b1;
        in_ch.speed_setpoint <= target;
        in_ch.left_count     <= left;
        in_ch.right_count    <= right;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // Stop offering words and wait until every predicted drive word has been
    // taken. The scoreboard's count is registered, hence the first wait.
    task automatic drain_loop();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only rewritten once the loop has gone quiet.
    task automatic load_settings(input logic [CFG_DATA_W-1:0] kp,
                                 input logic [CFG_DATA_W-1:0] ki,
                                 input logic [CFG_DATA_W-1:0] weight,
                                 input logic [CFG_DATA_W-1:0] limit);
        drain_loop();
        write_register(CFG_PROP_GAIN, kp);
        write_register(CFG_INT_GAIN, ki);
        write_register(CFG_WEIGHT, weight);
        write_register(CFG_LIMIT, limit);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [COUNT_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return COUNT_MIN;
            1:       return COUNT_MAX;
            2:       return '0;
            3:       return '1;
            default: return COUNT_BITS'(1);
        endcase
    endfunction

    // The receiver keeps its own rhythm: stretches of constant readiness,
    // coin-flip stalls, heavy stalls and periodic gaps. When asked, it also
    // holds off for a long stretch so that the block backs up onto its input.
    initial begin : ready_pattern
        int holds_served;
        int style;
        int span;
        int period;
        int k;
        holds_served = 0;
        forever begin
            if (holds_served < hold_requests) begin
                holds_served++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                style  = $urandom_range(0, 3);
                span   = $urandom_range(10, 80);
                period = $urandom_range(2, 6);
                for (k = 0; k < span; k++) begin
                    case (style)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= 1'($urandom_range(0, 1));
                        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: out_ch.ready <= ((k % period) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int sent;
        int burst;
        int gap;
        int hold_at;
        logic signed [COUNT_BITS-1:0] target;
        logic signed [COUNT_BITS-1:0] left;
        logic signed [COUNT_BITS-1:0] right;
        logic [CFG_DATA_W-1:0] kp;
        logic [CFG_DATA_W-1:0] ki;
        logic [CFG_DATA_W-1:0] weight;
        logic [CFG_DATA_W-1:0] limit;

        // Every input of the block is known from the first time step.
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.speed_setpoint <= '0;
        in_ch.left_count     <= '0;
        in_ch.right_count    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: zero error, the largest
        // errors of either sign, and odd sums where the halving must round
        // toward zero rather than down.
        send_sample('0, '0, '0);
        send_sample('0, COUNT_MAX, COUNT_MAX);
        send_sample('0, COUNT_MIN, COUNT_MIN);
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);
        send_sample(0, 1, 0);
        send_sample(0, -1, 0);
        send_sample(0, -3, 0);
        // A run of the largest positive error drives the integral into its clamp.
        repeat (6) send_sample(COUNT_MIN, COUNT_MAX, COUNT_MAX);

        // A write to an unmapped index must leave the loop untouched.
        drain_loop();
        write_register(CFG_UNMAPPED, '1);
        cfg_ch.valid <= 1'b0;
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);

        // Extreme gains with no smoothing and the widest clamp: the drive
        // value saturates at both ends.
        load_settings(GAIN_MIN, GAIN_MAX, '0, LIMIT_TOP);
        send_sample(COUNT_MIN, COUNT_MAX, COUNT_MAX);
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);
        send_sample(COUNT_MIN, COUNT_MAX, COUNT_MIN);
        send_sample('0, COUNT_MIN, COUNT_MAX);

        // A weight above one behaves as one, so the filter holds; a zero
        // clamp pins the integral.
        load_settings(GAIN_MAX, GAIN_MIN, WEIGHT_TOP, '0);
        send_sample(COUNT_MIN, COUNT_MAX, COUNT_MAX);
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);
        send_sample(0, 5, 7);

        load_settings(RST_PROP_GAIN, RST_INT_GAIN, WEIGHT_ONE, 24'd1);
        send_sample(COUNT_MAX, COUNT_MIN, COUNT_MIN);
        send_sample(0, 100, -20);

        // Random phases: each starts from a quiet loop with fresh settings,
        // then streams words in bursts. Most words look like real wheel
        // counts around a modest target so that the filter and integral
        // stay out of their limits; the rest span the whole field.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0: begin
                    kp     = RST_PROP_GAIN;
                    ki     = RST_INT_GAIN;
                    weight = RST_WEIGHT;
                    limit  = RST_LIMIT;
                end
                1: begin
                    kp     = CFG_DATA_W'($urandom);
                    ki     = CFG_DATA_W'($urandom);
                    weight = CFG_DATA_W'($urandom_range(0, 131071));
                    limit  = CFG_DATA_W'($urandom_range(0, 32767));
                end
                default: begin
                    kp     = CFG_DATA_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
                    ki     = CFG_DATA_W'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
                    weight = CFG_DATA_W'($urandom_range(0, 65536));
                    limit  = CFG_DATA_W'($urandom_range(0, 32767));
                end
            endcase
            load_settings(kp, ki, weight, limit);

            hold_at = $urandom_range(20, WORDS_PER_PHASE - 20);
            sent    = 0;
            while (sent < WORDS_PER_PHASE) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && sent < WORDS_PER_PHASE) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            target = COUNT_BITS'(int'($urandom_range(0, 400)) - 200);
                            left   = COUNT_BITS'(int'(target) +
                                                 int'($urandom_range(0, 60)) - 30);
                            right  = COUNT_BITS'(int'(target) +
                                                 int'($urandom_range(0, 60)) - 30);
                        end
                        6, 7, 8: begin
                            target = COUNT_BITS'($urandom);
                            left   = COUNT_BITS'($urandom);
                            right  = COUNT_BITS'($urandom);
                        end
                        default: begin
                            target = pick_extreme();
                            left   = pick_extreme();
                            right  = pick_extreme();
                        end
                    endcase
                    send_sample(target, left, right);
                    sent++;
                    burst--;
                    // Part-way through, the receiver is asked for its long hold
                    // while words keep being offered.
                    if (sent == hold_at) hold_requests <= hold_requests + 1;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        drain_loop();
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/vpl_pkg.sv
rtl/core/vpl_if.sv
rtl/core/vpl_ctrl.sv
rtl/core/vpl_dpath.sv
rtl/core/velocity_pi_with_lowpass.sv
tb/vpl_drive_checker.sv
tb/velocity_pi_with_lowpass_tb.sv
